FILE: rtl/four_level_page_map_builder_top_macros.svh
// ---------------------------------------------------------------------------
// Four-level page map builder assertion macros
// Shared assertion forms. Each expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_MAP_BUILDER_TOP_MACROS_SVH
`define FOUR_LEVEL_PAGE_MAP_BUILDER_TOP_MACROS_SVH

// same-cycle implication
`define FPMB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPMB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fpmb_pkg.sv
// ---------------------------------------------------------------------------
// fpmb_pkg
// Types, sizes and codes shared by the page map builder modules.
// ---------------------------------------------------------------------------
package fpmb_pkg;

	localparam int POOL_PAGES  = 16;
	localparam int IDX_W       = 9;
	localparam int ENTRIES     = 1 << IDX_W;
	localparam int FRAME_W     = 40;
	localparam int VA_HI_W     = 36;
	localparam int PAGE_W      = $clog2(POOL_PAGES + 1);
	localparam int REM_W       = $clog2(POOL_PAGES);
	localparam int ADDR_W      = PAGE_W + IDX_W;
	localparam int STORE_DEPTH = (POOL_PAGES + 1) * ENTRIES;
	localparam int ENT_W       = FRAME_W + 1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_LOW      = 3'd1,
		ST_EMPTY_L3 = 3'd2,
		ST_EMPTY_L2 = 3'd3,
		ST_EMPTY_L1 = 3'd4,
		ST_MAPPED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		LVL_ROOT = 2'd0,
		LVL_PDPT = 2'd1,
		LVL_DIR  = 2'd2,
		LVL_LEAF = 2'd3
	} level_t;

	typedef enum logic [3:0] {
		S_CLR_ROOT,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EVAL,
		S_CLEAR,
		S_LINK,
		S_REM_GO,
		S_REM_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic    load_item;
		logic    mem_rd;
		logic    wr_zero;
		logic    wr_link;
		logic    wr_leaf;
		logic    clr_step;
		logic    alloc;
		logic    take_frame;
		logic    rem_start;
		logic    descend;
		logic    set_code;
		status_t code;
		logic    out_load;
	} fpmb_cmd_t;

	typedef struct packed {
		level_t level;
		logic   low;
		logic   present;
		logic   pool_empty;
		logic   clr_last;
		logic   rem_done;
		logic   out_busy;
	} fpmb_stat_t;

endpackage

FILE: rtl/fpmb_rem.sv
// ---------------------------------------------------------------------------
// fpmb_rem
// Remainder of a frame offset by the pool size, registered on start.
// ---------------------------------------------------------------------------
module fpmb_rem
	import fpmb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [FRAME_W-1:0] dividend,
	output logic               done,
	output logic [REM_W-1:0]   rem
);

	logic [REM_W-1:0] r_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= start;
	end

	// pool size is a power of two, so this reduces to the low offset bits
	always_ff @(posedge clk) begin
		if (start)
			r_q <= REM_W'(dividend % FRAME_W'(POOL_PAGES));
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

FILE: rtl/fpmb_dp.sv
// ---------------------------------------------------------------------------
// fpmb_dp
// Table store, walk registers, pool counter, base register and result register.
// ---------------------------------------------------------------------------
module fpmb_dp
	import fpmb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  fpmb_cmd_t          cmd,
	output fpmb_stat_t         st,
	input  logic [47:0]        virt_addr,
	input  logic [51:0]        phys_addr,
	input  logic               cfg_wr,
	input  logic [FRAME_W-1:0] cfg_data,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [2:0]         status
);

	`include "four_level_page_map_builder_top_macros.svh"

	logic [ENT_W-1:0]   mem [STORE_DEPTH];
	logic [ENT_W-1:0]   rd_q;
	logic [VA_HI_W-1:0] va_hi_q;
	logic [FRAME_W-1:0] pa_frame_q;
	logic [FRAME_W-1:0] base_q;
	logic [FRAME_W-1:0] frame_q;
	logic [PAGE_W-1:0]  page_q;
	logic [PAGE_W-1:0]  used_q;
	logic [PAGE_W-1:0]  clr_page_q;
	logic [IDX_W-1:0]   cnt_q;
	level_t             level_q;
	status_t            code_q;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [IDX_W-1:0]   idx;
	logic [ADDR_W-1:0]  addr;
	logic [ENT_W-1:0]   wdata;
	logic               we;
	logic               rem_done;
	logic [REM_W-1:0]   rem;

	always_comb begin
		case (level_q)
			LVL_ROOT: idx = va_hi_q[35:27];
			LVL_PDPT: idx = va_hi_q[26:18];
			LVL_DIR:  idx = va_hi_q[17:9];
			default:  idx = va_hi_q[8:0];
		endcase
	end

	always_comb begin
		addr  = cmd.wr_zero ? {clr_page_q, cnt_q} : {page_q, idx};
		we    = cmd.wr_zero | cmd.wr_link | cmd.wr_leaf;
		wdata = '0;
		if (cmd.wr_link)
			wdata = {1'b1, frame_q};
		else if (cmd.wr_leaf)
			wdata = {1'b1, pa_frame_q};
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (cmd.mem_rd)
			rd_q <= mem[addr];
	end

	fpmb_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.rem_start),
		.dividend (frame_q - base_q),
		.done     (rem_done),
		.rem      (rem)
	);

	// item payload, frame scratch and status code
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			va_hi_q    <= virt_addr[47:12];
			pa_frame_q <= phys_addr[51:12];
		end
		if (cmd.take_frame)
			frame_q <= rd_q[FRAME_W-1:0];
		else if (cmd.alloc)
			frame_q <= base_q + FRAME_W'(used_q);
		if (cmd.set_code)
			code_q <= cmd.code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			used_q      <= '0;
			page_q      <= '0;
			clr_page_q  <= '0;
			cnt_q       <= '0;
			level_q     <= LVL_ROOT;
			out_valid_q <= 1'b0;
			status_q    <= '0;
		end else begin
			if (cfg_wr)
				base_q <= cfg_data;
			if (cmd.load_item) begin
				page_q  <= '0;
				level_q <= LVL_ROOT;
			end else if (cmd.descend) begin
				page_q  <= PAGE_W'(rem) + PAGE_W'(1);
				level_q <= level_t'(level_q + 2'd1);
			end
			if (cmd.alloc) begin
				used_q     <= used_q + PAGE_W'(1);
				clr_page_q <= used_q + PAGE_W'(1);
				cnt_q      <= '0;
			end else if (cmd.clr_step) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			// hold the result until taken
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				status_q    <= code_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.level      = level_q;
		st.low        = (va_hi_q[35:20] == '0);
		st.present    = rd_q[FRAME_W];
		st.pool_empty = (used_q >= PAGE_W'(POOL_PAGES));
		st.clr_last   = (cnt_q == IDX_W'(ENTRIES - 1));
		st.rem_done   = rem_done;
		st.out_busy   = out_valid_q & out_stall;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	`FPMB_ASSERT_IMPL(a_used_bound, 1'b1, used_q <= PAGE_W'(POOL_PAGES), "pool count past pool size")
	`FPMB_ASSERT_NEXT(a_alloc_step, cmd.alloc, used_q == $past(used_q) + PAGE_W'(1), "pool count did not advance")
	`FPMB_ASSERT_IMPL(a_page_bound, 1'b1, page_q <= PAGE_W'(POOL_PAGES), "walk page outside store")
	`FPMB_ASSERT_IMPL(a_one_write, 1'b1, $onehot0({cmd.wr_zero, cmd.wr_link, cmd.wr_leaf}), "two store writes at once")

endmodule

FILE: rtl/fpmb_ctrl.sv
// ---------------------------------------------------------------------------
// fpmb_ctrl
// Walk sequencer: root clear, level reads, page allocation, result handoff.
// ---------------------------------------------------------------------------
module fpmb_ctrl
	import fpmb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  fpmb_stat_t st,
	output fpmb_cmd_t  cmd
);

	`include "four_level_page_map_builder_top_macros.svh"

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR_ROOT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR_ROOT: if (st.clr_last) state_d = S_IDLE;
			S_IDLE:     if (in_valid) state_d = S_CHECK;
			S_CHECK:    state_d = st.low ? S_FINISH : S_READ;
			S_READ:     state_d = S_EVAL;
			S_EVAL: begin
				if (st.level == LVL_LEAF)
					state_d = S_FINISH;
				else if (st.present)
					state_d = S_REM_GO;
				else if (st.pool_empty)
					state_d = S_FINISH;
				else
					state_d = S_CLEAR;
			end
			S_CLEAR:    if (st.clr_last) state_d = S_LINK;
			S_LINK:     state_d = S_REM_GO;
			S_REM_GO:   state_d = S_REM_WAIT;
			S_REM_WAIT: if (st.rem_done) state_d = S_READ;
			S_FINISH:   if (!st.out_busy) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.code = ST_OK;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLR_ROOT: begin
				cmd.wr_zero  = 1'b1;
				cmd.clr_step = 1'b1;
			end
			S_IDLE: cmd.load_item = in_valid;
			S_CHECK: begin
				cmd.set_code = st.low;
				cmd.code     = ST_LOW;
			end
			S_READ: cmd.mem_rd = 1'b1;
			S_EVAL: begin
				if (st.level == LVL_LEAF) begin
					cmd.set_code = 1'b1;
					if (st.present) begin
						cmd.code = ST_MAPPED;
					end else begin
						cmd.code    = ST_OK;
						cmd.wr_leaf = 1'b1;
					end
				end else if (st.present) begin
					cmd.take_frame = 1'b1;
				end else if (st.pool_empty) begin
					cmd.set_code = 1'b1;
					case (st.level)
						LVL_ROOT: cmd.code = ST_EMPTY_L3;
						LVL_PDPT: cmd.code = ST_EMPTY_L2;
						default:  cmd.code = ST_EMPTY_L1;
					endcase
				end else begin
					cmd.alloc = 1'b1;
				end
			end
			S_CLEAR: begin
				cmd.wr_zero  = 1'b1;
				cmd.clr_step = 1'b1;
			end
			S_LINK:     cmd.wr_link = 1'b1;
			S_REM_GO:   cmd.rem_start = 1'b1;
			S_REM_WAIT: cmd.descend = st.rem_done;
			S_FINISH:   cmd.out_load = !st.out_busy;
			default:    cmd = '0;
		endcase
	end

	`FPMB_ASSERT_IMPL(a_alloc_avail, cmd.alloc, !st.pool_empty, "page taken from empty pool")
	`FPMB_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !st.out_busy, "result overwritten before taken")
	`FPMB_ASSERT_NEXT(a_load_walk, cmd.load_item, st.level == LVL_ROOT, "walk did not restart at root")

endmodule

FILE: rtl/four_level_page_map_builder_top.sv
// ---------------------------------------------------------------------------
// four_level_page_map_builder_top
// Maps 4 KiB virtual pages into a four-level table kept in an on-chip store.
//
//   channel   signals                         direction
//   request   in_valid/in_stall, virt_addr,   in
//             phys_addr
//   result    out_valid/out_stall, status     out
//   config    cfg_valid/cfg_ready,            in
//             pool_base_frame
//
// One request at a time. A request below 4 GiB ends right after its check; a walk
// ends early when the pool runs out at level 3, 2 or 1, and otherwise passes over
// every upper level (read, check, remainder and descend per upper level).
// Each table page taken from the pool is cleared one entry a cycle, then linked.
// After reset the root page is cleared; in_stall stays high meanwhile.
// A waiting result is held while the next request is taken.
// ---------------------------------------------------------------------------
module four_level_page_map_builder_top
	import fpmb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [47:0]        virt_addr,
	input  logic [51:0]        phys_addr,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FRAME_W-1:0] pool_base_frame
);

	fpmb_cmd_t  cmd;
	fpmb_stat_t st;

	assign cfg_ready = 1'b1;

	fpmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	fpmb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.virt_addr (virt_addr),
		.phys_addr (phys_addr),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_data  (pool_base_frame),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status)
	);

endmodule

FILE: verif/four_level_page_map_builder_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// four_level_page_map_builder_checker
// Watches the request, result and config channels of the page map builder.
// Keeps a shadow copy of the table store and the pool, predicts the status
// of each accepted request and compares it with the returned status.
// ---------------------------------------------------------------------------
module four_level_page_map_builder_checker
	import fpmb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [47:0]        virt_addr,
	input  logic [51:0]        phys_addr,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         status,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [FRAME_W-1:0] pool_base_frame,
	output int                 fail_count,
	output int                 pending,
	output int                 pool_taken
);

	logic [63:0]        shadow_tables [STORE_DEPTH];
	logic [FRAME_W-1:0] base_frame;
	int                 pages_taken;
	int                 mismatches;
	status_t            status_due [$];
	status_t            want;

	// Walk the shadow tables for one request, taking pool pages as needed.
	function automatic status_t map_page(input logic [47:0] va, input logic [51:0] pa);
		int                 page;
		int                 slot;
		int                 fresh;
		logic [8:0]         idx;
		logic [FRAME_W-1:0] frame;
		logic [FRAME_W-1:0] offset;
		logic [63:0]        entry;
		if (va < 48'h1_0000_0000)
			return ST_LOW;
		page = 0;
		for (int lvl = 0; lvl < 3; lvl++) begin
			idx   = va[47 - 9 * lvl -: 9];
			slot  = page * ENTRIES + int'(idx);
			entry = shadow_tables[slot];
			if (!entry[0]) begin
				if (pages_taken >= POOL_PAGES) begin
					case (lvl)
					0:       return ST_EMPTY_L3;
					1:       return ST_EMPTY_L2;
					default: return ST_EMPTY_L1;
					endcase
				end
				fresh = pages_taken;
				pages_taken++;
				for (int k = 0; k < ENTRIES; k++)
					shadow_tables[(fresh + 1) * ENTRIES + k] = '0;
				frame = base_frame + FRAME_W'(fresh);
				entry = {12'd0, frame, 10'd0, 2'b11};
				shadow_tables[slot] = entry;
			end
			// decode with the current base, wrapping in 40 bits
			frame  = entry[51:12];
			offset = frame - base_frame;
			page   = int'(offset % FRAME_W'(POOL_PAGES)) + 1;
		end
		slot = page * ENTRIES + int'(va[20:12]);
		if (shadow_tables[slot][0])
			return ST_MAPPED;
		shadow_tables[slot] = {12'd0, pa[51:12], 10'd0, 2'b11};
		return ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STORE_DEPTH; k++)
				shadow_tables[k] = '0;
			pages_taken = 0;
			base_frame  = '0;
			mismatches  = 0;
			status_due.delete();
			fail_count <= 0;
			pending    <= 0;
			pool_taken <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				base_frame = pool_base_frame;
			if (in_valid && !in_stall)
				status_due.push_back(map_page(virt_addr, phys_addr));
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$error("status: no request waiting, got %0d", status);
					mismatches++;
				end else begin
					want = status_due.pop_front();
					if (status !== want) begin
						$error("status: expected %0d (%s), got %0d", want, want.name(), status);
						mismatches++;
					end
				end
			end
			fail_count <= mismatches;
			pending    <= status_due.size();
			pool_taken <= pages_taken;
		end
	end

endmodule

FILE: verif/four_level_page_map_builder_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// four_level_page_map_builder_top_test
// Drives map requests and pool base writes into the page map builder with
// random idling on both channels. Directed walks cover low addresses, first
// and repeated mappings, base rewrites and pool exhaustion at every level;
// random phases then hammer the built paths. The checker scores statuses.
// ---------------------------------------------------------------------------
module four_level_page_map_builder_top_test;
	import fpmb_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [47:0]        virt_addr;
	logic [51:0]        phys_addr;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [FRAME_W-1:0] pool_base_frame;
	int                 fail_count;
	int                 pending;
	int                 pool_taken;
	bit                 calm_in;
	bit                 calm_out;
	int                 n_requests;
	int                 n_bases;

	always #5 clk = ~clk;

	four_level_page_map_builder_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.virt_addr       (virt_addr),
		.phys_addr       (phys_addr),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.pool_base_frame (pool_base_frame)
	);

	four_level_page_map_builder_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.virt_addr       (virt_addr),
		.phys_addr       (phys_addr),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.pool_base_frame (pool_base_frame),
		.fail_count      (fail_count),
		.pending         (pending),
		.pool_taken      (pool_taken)
	);

	function automatic logic [47:0] va_of(input logic [8:0] l4, input logic [8:0] l3,
			input logic [8:0] l2, input logic [8:0] l1, input logic [11:0] off);
		return {l4, l3, l2, l1, off};
	endfunction

	// Hold stall for a drawn number of cycles, then take one result.
	initial begin : result_sink
		int hold;
		out_stall = 1'b1;
		forever begin
			hold = calm_out ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	task automatic send(input logic [47:0] va, input logic [51:0] pa);
		int gap;
		gap = calm_in ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		virt_addr <= va;
		phys_addr <= pa;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_requests++;
	endtask

	// Write the base only when the block is drained. Unless free is set and the pool
	// is full, force the low nibble to F so every taken page still decodes to itself.
	task automatic write_base(input logic [FRAME_W-1:0] value, input bit free);
		logic [FRAME_W-1:0] b;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		b = value;
		if (!free || pool_taken < POOL_PAGES)
			b[3:0] = 4'hF;
		cfg_valid       <= 1'b1;
		pool_base_frame <= b;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		n_bases++;
	endtask

	task automatic send_random();
		logic [47:0] va;
		logic [51:0] pa;
		logic [8:0]  l4;
		logic [8:0]  l3;
		logic [8:0]  l2;
		int          mode;
		mode = $urandom_range(0, 99);
		pa   = 52'({$urandom, $urandom});
		if (mode < 8) begin
			va = {16'd0, 32'($urandom)};
		end else if (mode < 85) begin
			// mostly paths that the directed part built
			case ($urandom_range(0, 7))
			0: begin
				l4 = 9'd0;   l3 = 9'd4;   l2 = 9'd0;
			end
			1: begin
				l4 = 9'd511; l3 = 9'd511; l2 = 9'd511;
			end
			2: begin
				l4 = 9'd1;   l3 = 9'd5;   l2 = 9'd1;
			end
			3: begin
				l4 = 9'd2;   l3 = 9'd5;   l2 = 9'd1;
			end
			4: begin
				l4 = 9'd3;   l3 = 9'd5;   l2 = 9'd1;
			end
			5: begin
				l4 = 9'd4;   l3 = 9'd5;   l2 = 9'd1;
			end
			default: begin
				l4 = 9'($urandom_range(0, 5));
				l3 = 9'($urandom_range(4, 6));
				l2 = 9'($urandom_range(0, 2));
				if ($urandom_range(0, 3) == 0)
					l4 = 9'd511;
			end
			endcase
			va = va_of(l4, l3, l2, 9'($urandom), 12'($urandom));
		end else begin
			va = 48'({$urandom, $urandom});
		end
		send(va, pa);
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		virt_addr       = '0;
		phys_addr       = '0;
		cfg_valid       = 1'b0;
		pool_base_frame = '0;
		calm_in         = 1'b0;
		calm_out        = 1'b0;
		n_requests      = 0;
		n_bases         = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// top base value: pool frames wrap past the 40-bit limit
		write_base(40'hFF_FFFF_FFFF, 1'b0);
		send(48'h0, 52'h0);
		send(48'h0000_FFFF_FFFF, 52'h5_5555_5555_5555);
		send(va_of(9'd0, 9'd4, 9'd0, 9'd0, 12'd0), 52'hF_FFFF_FFFF_FFFF);
		send(va_of(9'd0, 9'd4, 9'd0, 9'd0, 12'd0), 52'h0);
		send(48'hFFFF_FFFF_FFFF, 52'h0);
		send(va_of(9'd511, 9'd511, 9'd511, 9'd510, 12'd0), 52'hA_AAAA_AAAA_AAAA);
		send(48'hFFFF_FFFF_FFFF, 52'h1234_5678_9ABC);

		// rewrite the base after use, then fill the pool
		write_base(40'h0F, 1'b0);
		send(va_of(9'd511, 9'd511, 9'd511, 9'd0, 12'd0), 52'h8_0000_0000_1000);
		send(va_of(9'd1, 9'd5, 9'd1, 9'd0, 12'hABC), 52'h1000);
		send(va_of(9'd2, 9'd5, 9'd1, 9'd0, 12'd0), 52'h2000);
		send(va_of(9'd3, 9'd5, 9'd1, 9'd0, 12'd0), 52'h3000);
		send(va_of(9'd4, 9'd5, 9'd1, 9'd0, 12'd0), 52'h4000);
		send(va_of(9'd5, 9'd5, 9'd1, 9'd0, 12'd0), 52'h5000);
		send(va_of(9'd1, 9'd5, 9'd2, 9'd0, 12'd0), 52'h6000);
		send(va_of(9'd1, 9'd6, 9'd1, 9'd0, 12'd0), 52'h7000);
		send(va_of(9'd4, 9'd5, 9'd1, 9'd0, 12'd0), 52'h8000);

		// pool is full: any base is legal, decoding shifts across taken pages
		write_base(40'h0, 1'b1);
		send(va_of(9'd1, 9'd5, 9'd1, 9'd3, 12'd0), 52'h9000);
		send(va_of(9'd511, 9'd511, 9'd511, 9'd7, 12'd0), 52'hA000);
		send(va_of(9'd0, 9'd4, 9'd0, 9'd0, 12'd0), 52'hB000);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			1:       write_base(40'hFF_FFFF_FFFF, 1'b0);
			2:       write_base(40'h0, 1'b1);
			default: write_base(40'({$urandom, $urandom}), $urandom_range(0, 3) == 0);
			endcase
			calm_in  = $urandom_range(0, 3) == 0;
			calm_out = $urandom_range(0, 3) == 0;
			repeat (125) send_random();
		end

		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (40) @(posedge clk);
		$display("covered %0d map requests over %0d pool base settings", n_requests, n_bases);
		$display("  incl. low addresses, remaps, pool exhaustion at each level, shifted bases");
		if (fail_count == 0)
			$display("four_level_page_map_builder_top_test: PASS");
		else
			$display("four_level_page_map_builder_top_test: FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("four_level_page_map_builder_top_test: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/fpmb_pkg.sv
rtl/fpmb_rem.sv
rtl/fpmb_dp.sv
rtl/fpmb_ctrl.sv
rtl/four_level_page_map_builder_top.sv
verif/four_level_page_map_builder_checker.sv
verif/four_level_page_map_builder_top_test.sv
